### rtl/dle_stx_etx_deframer_core_macros.svh
// ----------------------------------------------------------------------------
// dle_stx_etx_deframer_core_macros
// Assertion macros used by the deframer top level.
// ----------------------------------------------------------------------------
`ifndef DLE_STX_ETX_DEFRAMER_CORE_MACROS_SVH
`define DLE_STX_ETX_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DSED_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DSED_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

### rtl/dsed_pkg.sv
// ----------------------------------------------------------------------------
// dsed_pkg
// Shared constants and types of the escape-framed byte deframer.
// ----------------------------------------------------------------------------
package dsed_pkg;

  localparam int MAX_FRAME = 64;
  localparam int ADDR_W    = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam int LEN_W     = $clog2(MAX_FRAME + 1);
  localparam int BYTE_W    = 8;
  localparam int ACT_W     = 2;
  localparam int IDX_W     = 2;

  // Command queue between parser and emitter.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_BYTE       = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BYTE_FLUSH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH      = 2'd2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_ESCAPE = 2'd0;
  localparam logic [IDX_W-1:0] REG_START  = 2'd1;
  localparam logic [IDX_W-1:0] REG_END    = 2'd2;

  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'd16;
  localparam logic [BYTE_W-1:0] START_RESET  = 8'd2;
  localparam logic [BYTE_W-1:0] END_RESET    = 8'd3;

  // Run kinds; also selects the store.
  localparam logic KIND_FRAME   = 1'b0;
  localparam logic KIND_GARBAGE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic              sel;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } wr_t;

endpackage

### rtl/dsed_if.sv
// ----------------------------------------------------------------------------
// dsed_if
// Valid/ready channels of the deframer: raw byte input and run output.
// ----------------------------------------------------------------------------
interface dsed_in_if;
  logic                       valid;
  logic                       ready;
  logic [dsed_pkg::ACT_W-1:0]  action;
  logic [dsed_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, action, data_byte, input ready);
  modport sink   (input valid, action, data_byte, output ready);
endinterface

interface dsed_out_if;
  logic                       valid;
  logic                       ready;
  logic [dsed_pkg::BYTE_W-1:0] out_byte;
  logic                       kind;
  logic                       last;

  modport source (output valid, out_byte, kind, last, input ready);
  modport sink   (input valid, out_byte, kind, last, output ready);
endinterface

### rtl/dle_stx_etx_deframer_core.sv
// ----------------------------------------------------------------------------
// dle_stx_etx_deframer_core
// Escape-framed byte deframer: parses escape/start/end sequences, collects
// frame payload and stray bytes, and emits them as runs of bytes.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  byte_in   in   valid/ready    action[1:0], data_byte[7:0]
//  run_out   out  valid/ready    out_byte[7:0], kind, last
//  cfg       in   cfg_we         cfg_index[1:0], cfg_data[7:0]
//
// A transfer that emits nothing leaves byte_in ready, but an escape followed by
// an ordinary byte outside a frame holds byte_in off while the second garbage
// byte is written, as the garbage store has one write port. A run of N bytes
// holds byte_in off until the emitter has read all N store entries.
// A stall on run_out holds the emitter and, while a run is queued, byte_in.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`include "dle_stx_etx_deframer_core_macros.svh"

module dle_stx_etx_deframer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [dsed_pkg::IDX_W-1:0]  cfg_index,
  input  logic [dsed_pkg::BYTE_W-1:0] cfg_data,
  dsed_in_if.sink                     byte_in,
  dsed_out_if.source                  run_out
);

  dsed_pkg::wr_t  mem_wr;
  dsed_pkg::cmd_t cmd;
  dsed_pkg::cmd_t head;
  logic           cmd_push;
  logic           q_valid;
  logic           q_pop;
  logic           rd_issue;

  dsed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_in   (byte_in),
    .q_busy    (q_valid),
    .mem_wr    (mem_wr),
    .cmd       (cmd),
    .cmd_push  (cmd_push)
  );

  dsed_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (head)
  );

  dsed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mem_wr     (mem_wr),
    .head_valid (q_valid),
    .head       (head),
    .pop        (q_pop),
    .rd_issue   (rd_issue),
    .run_out    (run_out)
  );

  // The parser only takes a byte once the emitter has finished reading.
  `DSED_ASSERT_IMPL(a_accept_when_drained, clk, rst, byte_in.valid && byte_in.ready, !q_valid)
  // Store writes and emitter reads never overlap.
  `DSED_ASSERT_IMPL(a_no_write_during_read, clk, rst, mem_wr.en, !rd_issue)
  // At most one run is ever outstanding.
  `DSED_ASSERT_NEXT(a_pop_drains_queue, clk, rst, q_pop, !q_valid)

endmodule

### rtl/dsed_front.sv
// ----------------------------------------------------------------------------
// dsed_front
// Escape parser: takes input bytes, fills the stores and queues run commands.
// ----------------------------------------------------------------------------
module dsed_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [dsed_pkg::IDX_W-1:0]  cfg_index,
  input  logic [dsed_pkg::BYTE_W-1:0] cfg_data,
  dsed_in_if.sink                     byte_in,
  input  logic                        q_busy,
  output dsed_pkg::wr_t               mem_wr,
  output dsed_pkg::cmd_t              cmd,
  output logic                        cmd_push
);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_ESC,
    MODE_FRAME,
    MODE_FRAME_ESC
  } mode_t;

  localparam logic [dsed_pkg::LEN_W-1:0] MAX_LEN = dsed_pkg::LEN_W'(dsed_pkg::MAX_FRAME);

  mode_t                       mode, mode_next;
  logic [dsed_pkg::LEN_W-1:0]  flen, flen_next;
  logic [dsed_pkg::LEN_W-1:0]  glen, glen_next;
  logic [dsed_pkg::BYTE_W-1:0] escape_code, start_code, end_code;
  logic                        pend_valid, pend_valid_next;
  logic [dsed_pkg::BYTE_W-1:0] pend_byte, pend_byte_next;
  logic                        pend_flush, pend_flush_next;

  logic                        accept;
  logic                        proc;
  logic                        flush;
  logic [dsed_pkg::BYTE_W-1:0] b;

  assign byte_in.ready = !pend_valid && !q_busy;
  assign accept = byte_in.valid && byte_in.ready;
  assign b      = byte_in.data_byte;
  assign proc   = (byte_in.action == dsed_pkg::ACT_BYTE) ||
                  (byte_in.action == dsed_pkg::ACT_BYTE_FLUSH);
  assign flush  = (byte_in.action != dsed_pkg::ACT_BYTE);

  always_comb begin
    mode_next       = mode;
    flen_next       = flen;
    glen_next       = glen;
    pend_valid_next = 1'b0;
    pend_byte_next  = pend_byte;
    pend_flush_next = pend_flush;
    mem_wr          = '0;
    cmd             = '0;
    cmd_push        = 1'b0;

    if (pend_valid) begin
      // Second garbage byte of an escape followed by an ordinary byte.
      if (glen < MAX_LEN) begin
        mem_wr.en   = 1'b1;
        mem_wr.sel  = dsed_pkg::KIND_GARBAGE;
        mem_wr.addr = glen[dsed_pkg::ADDR_W-1:0];
        mem_wr.data = pend_byte;
        glen_next   = glen + 1'b1;
      end
      if (pend_flush) begin
        cmd_push  = 1'b1;
        cmd.kind  = dsed_pkg::KIND_GARBAGE;
        cmd.len   = glen_next;
        glen_next = '0;
      end
    end else if (accept) begin
      if (proc) begin
        case (mode)
          MODE_IDLE: begin
            if (b == escape_code) begin
              mode_next = MODE_ESC;
            end else if (glen < MAX_LEN) begin
              mem_wr.en   = 1'b1;
              mem_wr.sel  = dsed_pkg::KIND_GARBAGE;
              mem_wr.addr = glen[dsed_pkg::ADDR_W-1:0];
              mem_wr.data = b;
              glen_next   = glen + 1'b1;
            end
          end
          MODE_ESC: begin
            if (b == start_code) begin
              if (glen != '0) begin
                cmd_push = 1'b1;
                cmd.kind = dsed_pkg::KIND_GARBAGE;
                cmd.len  = glen;
              end
              glen_next = '0;
              flen_next = '0;
              mode_next = MODE_FRAME;
            end else begin
              if (glen < MAX_LEN) begin
                mem_wr.en   = 1'b1;
                mem_wr.sel  = dsed_pkg::KIND_GARBAGE;
                mem_wr.addr = glen[dsed_pkg::ADDR_W-1:0];
                mem_wr.data = escape_code;
                glen_next   = glen + 1'b1;
              end
              if (b != escape_code) begin
                pend_valid_next = 1'b1;
                pend_byte_next  = b;
                pend_flush_next = flush;
                mode_next       = MODE_IDLE;
              end
            end
          end
          MODE_FRAME: begin
            if (b == escape_code) begin
              mode_next = MODE_FRAME_ESC;
            end else if (flen < MAX_LEN) begin
              mem_wr.en   = 1'b1;
              mem_wr.sel  = dsed_pkg::KIND_FRAME;
              mem_wr.addr = flen[dsed_pkg::ADDR_W-1:0];
              mem_wr.data = b;
              flen_next   = flen + 1'b1;
            end else begin
              mode_next = MODE_IDLE;
              flen_next = '0;
            end
          end
          MODE_FRAME_ESC: begin
            if (b == end_code) begin
              if (flen != '0) begin
                cmd_push = 1'b1;
                cmd.kind = dsed_pkg::KIND_FRAME;
                cmd.len  = flen;
              end
              mode_next = MODE_IDLE;
              flen_next = '0;
            end else if (b == escape_code) begin
              if (flen < MAX_LEN) begin
                mem_wr.en   = 1'b1;
                mem_wr.sel  = dsed_pkg::KIND_FRAME;
                mem_wr.addr = flen[dsed_pkg::ADDR_W-1:0];
                mem_wr.data = escape_code;
                flen_next   = flen + 1'b1;
                mode_next   = MODE_FRAME;
              end else begin
                mode_next = MODE_IDLE;
                flen_next = '0;
              end
            end else if (b == start_code) begin
              mode_next = MODE_FRAME;
              flen_next = '0;
            end else begin
              mode_next = MODE_IDLE;
              flen_next = '0;
            end
          end
          default: begin
            mode_next = MODE_IDLE;
          end
        endcase
      end
      // Garbage is empty inside a frame, so a flush never competes with a
      // frame run. A flush behind a pending byte waits for that byte.
      if (flush && !pend_valid_next) begin
        if (glen_next != '0) begin
          cmd_push = 1'b1;
          cmd.kind = dsed_pkg::KIND_GARBAGE;
          cmd.len  = glen_next;
        end
        glen_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      flen        <= '0;
      glen        <= '0;
      pend_valid  <= 1'b0;
      escape_code <= dsed_pkg::ESCAPE_RESET;
      start_code  <= dsed_pkg::START_RESET;
      end_code    <= dsed_pkg::END_RESET;
    end else begin
      mode       <= mode_next;
      flen       <= flen_next;
      glen       <= glen_next;
      pend_valid <= pend_valid_next;
      if (cfg_we) begin
        case (cfg_index)
          dsed_pkg::REG_ESCAPE: escape_code <= cfg_data;
          dsed_pkg::REG_START:  start_code  <= cfg_data;
          dsed_pkg::REG_END:    end_code    <= cfg_data;
          default: ;
        endcase
      end
    end
    pend_byte  <= pend_byte_next;
    pend_flush <= pend_flush_next;
  end

endmodule

### rtl/dsed_cmd_fifo.sv
// ----------------------------------------------------------------------------
// dsed_cmd_fifo
// Short queue of run commands between the parser and the emitter.
// ----------------------------------------------------------------------------
module dsed_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dsed_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           head_valid,
  output dsed_pkg::cmd_t head
);

  dsed_pkg::cmd_t              entries [dsed_pkg::QDEPTH];
  logic [dsed_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [dsed_pkg::QCNT_W-1:0] count;
  logic                        do_push, do_pop;

  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && (count != dsed_pkg::QCNT_W'(dsed_pkg::QDEPTH));
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

### rtl/dsed_back.sv
// ----------------------------------------------------------------------------
// dsed_back
// Run emitter: holds the frame and garbage stores and streams a queued run
// out of one of them, one byte per cycle while run_out is not stalled.
// ----------------------------------------------------------------------------
module dsed_back (
  input  logic           clk,
  input  logic           rst,
  input  dsed_pkg::wr_t  mem_wr,
  input  logic           head_valid,
  input  dsed_pkg::cmd_t head,
  output logic           pop,
  output logic           rd_issue,
  dsed_out_if.source     run_out
);

  logic [dsed_pkg::BYTE_W-1:0] frame_mem   [dsed_pkg::MAX_FRAME];
  logic [dsed_pkg::BYTE_W-1:0] garbage_mem [dsed_pkg::MAX_FRAME];

  logic [dsed_pkg::ADDR_W-1:0] idx;
  logic                        out_valid;
  logic                        out_kind;
  logic                        out_last;
  logic [dsed_pkg::BYTE_W-1:0] frame_rd, garbage_rd;
  logic                        is_last;

  // The read data registers double as the output register.
  assign rd_issue = head_valid && (!out_valid || run_out.ready);
  assign is_last  = ({1'b0, idx} + 1'b1) == head.len;
  assign pop      = rd_issue && is_last;

  assign run_out.valid    = out_valid;
  assign run_out.out_byte = (out_kind == dsed_pkg::KIND_GARBAGE) ? garbage_rd : frame_rd;
  assign run_out.kind     = out_kind;
  assign run_out.last     = out_last;

  always_ff @(posedge clk) begin
    if (mem_wr.en && (mem_wr.sel == dsed_pkg::KIND_FRAME)) begin
      frame_mem[mem_wr.addr] <= mem_wr.data;
    end
    if (rd_issue && (head.kind == dsed_pkg::KIND_FRAME)) begin
      frame_rd <= frame_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr.en && (mem_wr.sel == dsed_pkg::KIND_GARBAGE)) begin
      garbage_mem[mem_wr.addr] <= mem_wr.data;
    end
    if (rd_issue && (head.kind == dsed_pkg::KIND_GARBAGE)) begin
      garbage_rd <= garbage_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (rd_issue) begin
      out_valid <= 1'b1;
      idx       <= is_last ? '0 : idx + 1'b1;
    end else if (run_out.ready) begin
      out_valid <= 1'b0;
    end
    if (rd_issue) begin
      out_kind <= head.kind;
      out_last <= is_last;
    end
  end

endmodule

### sim/dle_stx_etx_deframer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dle_stx_etx_deframer_core_test
// Self-checking bench for the escape-framed byte deframer. A scoreboard class
// tracks the escape parser, the frame store and the stray-byte store, queues
// the bytes that each input transfer should release, and checks every output
// transfer against them in order. Directed corner cases run first, then random
// framed traffic under several code settings, most of it with random stalls on both sides.
// ----------------------------------------------------------------------------
module dle_stx_etx_deframer_core_test;

  localparam logic [dsed_pkg::ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam logic [dsed_pkg::IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int LONG_HOLD      = 300;
  localparam int SETTLE_CYCLES  = 8;

  typedef enum logic [1:0] {
    PARSE_IDLE, PARSE_ESC, PARSE_FRAME, PARSE_FRAME_ESC
  } parse_state_t;

  typedef struct packed {
    logic [dsed_pkg::BYTE_W-1:0] out_byte;
    logic                        kind;
    logic                        last;
  } run_byte_t;

  typedef struct packed {
    logic [dsed_pkg::ACT_W-1:0]  act;
    logic [dsed_pkg::BYTE_W-1:0] data;
  } raw_item_t;

  class deframe_runs;
    logic [dsed_pkg::BYTE_W-1:0] escape_code;
    logic [dsed_pkg::BYTE_W-1:0] start_code;
    logic [dsed_pkg::BYTE_W-1:0] end_code;
    parse_state_t                state;
    logic [dsed_pkg::BYTE_W-1:0] frame_buf[dsed_pkg::MAX_FRAME];
    logic [dsed_pkg::BYTE_W-1:0] stray_buf[dsed_pkg::MAX_FRAME];
    int                          frame_len;
    int                          stray_len;
    run_byte_t                   pending_bytes[$];
    int                          errors;

    function new();
      escape_code = dsed_pkg::ESCAPE_RESET;
      start_code  = dsed_pkg::START_RESET;
      end_code    = dsed_pkg::END_RESET;
      state       = PARSE_IDLE;
      frame_len   = 0;
      stray_len   = 0;
      errors      = 0;
    endfunction

    function void write_code(logic [dsed_pkg::IDX_W-1:0] idx,
                             logic [dsed_pkg::BYTE_W-1:0] value);
      case (idx)
        dsed_pkg::REG_ESCAPE: escape_code = value;
        dsed_pkg::REG_START:  start_code = value;
        dsed_pkg::REG_END:    end_code = value;
        default: ;
      endcase
    endfunction

    function void queue_run(logic kind, int len);
      run_byte_t item;
      for (int i = 0; i < len; i++) begin
        item.out_byte = (kind == dsed_pkg::KIND_FRAME) ? frame_buf[i] : stray_buf[i];
        item.kind     = kind;
        item.last     = (i == len - 1);
        pending_bytes.insert(pending_bytes.size(), item);
      end
    endfunction

    function void keep_stray(logic [dsed_pkg::BYTE_W-1:0] b);
      if (stray_len < dsed_pkg::MAX_FRAME) begin
        stray_buf[stray_len] = b;
        stray_len++;
      end
    endfunction

    function void flush_stray();
      queue_run(dsed_pkg::KIND_GARBAGE, stray_len);
      stray_len = 0;
    endfunction

    function void drop_frame();
      state     = PARSE_IDLE;
      frame_len = 0;
    endfunction

    function void take_byte(logic [dsed_pkg::BYTE_W-1:0] b);
      case (state)
        PARSE_IDLE: begin
          if (b == escape_code) state = PARSE_ESC;
          else keep_stray(b);
        end
        PARSE_ESC: begin
          if (b == start_code) begin
            flush_stray();
            state     = PARSE_FRAME;
            frame_len = 0;
          end else if (b == escape_code) begin
            // The first escape of a pair is stray; the parser keeps waiting.
            keep_stray(escape_code);
          end else begin
            keep_stray(escape_code);
            keep_stray(b);
            state = PARSE_IDLE;
          end
        end
        PARSE_FRAME: begin
          if (b == escape_code) begin
            state = PARSE_FRAME_ESC;
          end else if (frame_len < dsed_pkg::MAX_FRAME) begin
            frame_buf[frame_len] = b;
            frame_len++;
          end else begin
            drop_frame();
          end
        end
        default: begin
          // Inside a frame the end code wins over escape, and escape over start.
          if (b == end_code) begin
            queue_run(dsed_pkg::KIND_FRAME, frame_len);
            drop_frame();
          end else if (b == escape_code) begin
            if (frame_len < dsed_pkg::MAX_FRAME) begin
              frame_buf[frame_len] = escape_code;
              frame_len++;
              state = PARSE_FRAME;
            end else begin
              drop_frame();
            end
          end else if (b == start_code) begin
            state     = PARSE_FRAME;
            frame_len = 0;
          end else begin
            drop_frame();
          end
        end
      endcase
    endfunction

    function void note_transfer(logic [dsed_pkg::ACT_W-1:0] act,
                                logic [dsed_pkg::BYTE_W-1:0] b);
      if (act == dsed_pkg::ACT_BYTE || act == dsed_pkg::ACT_BYTE_FLUSH) take_byte(b);
      if (act != dsed_pkg::ACT_BYTE) flush_stray();
    endfunction

    function void check_transfer(logic [dsed_pkg::BYTE_W-1:0] got_byte, logic got_kind,
                                 logic got_last);
      run_byte_t want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected output: expected none, actual byte %h kind %0d last %0d",
                 $time, got_byte, got_kind, got_last);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (got_byte !== want.out_byte) begin
        $display("%0t: out_byte mismatch: expected %h actual %h",
                 $time, want.out_byte, got_byte);
        errors++;
      end
      if (got_kind !== want.kind) begin
        $display("%0t: kind mismatch: expected %0d actual %0d", $time, want.kind, got_kind);
        errors++;
      end
      if (got_last !== want.last) begin
        $display("%0t: last mismatch: expected %0d actual %0d", $time, want.last, got_last);
        errors++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [dsed_pkg::IDX_W-1:0]  cfg_index;
  logic [dsed_pkg::BYTE_W-1:0] cfg_data;

  dsed_in_if  byte_in ();
  dsed_out_if run_out ();

  deframe_runs board = new();

  bit send_gaps    = 1'b0;
  bit recv_stalls  = 1'b0;
  bit hold_request = 1'b0;
  int items_sent   = 0;
  int idle_cycles  = 0;

  dle_stx_etx_deframer_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_in   (byte_in),
    .run_out   (run_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    run_out.ready <= 1'b1;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        run_out.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
        run_out.ready <= 1'b1;
      end else if (recv_stalls && $urandom_range(0, 7) == 0) begin
        run_out.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
        run_out.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_in.valid && byte_in.ready)
        board.note_transfer(byte_in.action, byte_in.data_byte);
      if (run_out.valid && run_out.ready)
        board.check_transfer(run_out.out_byte, run_out.kind, run_out.last);
      if ((byte_in.valid && byte_in.ready) || (run_out.valid && run_out.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // Called right after a falling edge; returns at the falling edge that
  // follows the transfer, with valid still high.
  task automatic send_item(input logic [dsed_pkg::ACT_W-1:0] act,
                           input logic [dsed_pkg::BYTE_W-1:0] b);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      byte_in.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    byte_in.valid     <= 1'b1;
    byte_in.action    <= act;
    byte_in.data_byte <= b;
    @(posedge clk);
    while (!byte_in.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic settle();
    byte_in.valid <= 1'b0;
    while (board.pending_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [dsed_pkg::IDX_W-1:0] idx,
                           input logic [dsed_pkg::BYTE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    board.write_code(idx, value);
    @(negedge clk);
  endtask

  task automatic write_codes(input logic [dsed_pkg::BYTE_W-1:0] esc,
                             input logic [dsed_pkg::BYTE_W-1:0] start,
                             input logic [dsed_pkg::BYTE_W-1:0] stop);
    write_reg(dsed_pkg::REG_ESCAPE, esc);
    write_reg(dsed_pkg::REG_START, start);
    write_reg(dsed_pkg::REG_END, stop);
    cfg_we <= 1'b0;
  endtask

  // Biased toward the three code values so that every parser branch is hit.
  function automatic logic [dsed_pkg::BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1: return board.escape_code;
      2:    return board.start_code;
      3:    return board.end_code;
      default: return dsed_pkg::BYTE_W'($urandom);
    endcase
  endfunction

  function automatic logic [dsed_pkg::BYTE_W-1:0] pick_plain();
    logic [dsed_pkg::BYTE_W-1:0] b;
    do b = dsed_pkg::BYTE_W'($urandom); while (b == board.escape_code);
    return b;
  endfunction

  task automatic send_frame(input int len);
    logic [dsed_pkg::BYTE_W-1:0] b;
    send_item(dsed_pkg::ACT_BYTE, board.escape_code);
    send_item(dsed_pkg::ACT_BYTE, board.start_code);
    for (int i = 0; i < len; i++) begin
      b = pick_byte();
      send_item(($urandom_range(0, 15) == 0) ? dsed_pkg::ACT_BYTE_FLUSH : dsed_pkg::ACT_BYTE,
                b);
      if (b == board.escape_code) send_item(dsed_pkg::ACT_BYTE, b);
    end
    send_item(dsed_pkg::ACT_BYTE, board.escape_code);
    send_item(dsed_pkg::ACT_BYTE, board.end_code);
  endtask

  task automatic run_traffic(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          repeat ($urandom_range(1, 6))
            send_item(dsed_pkg::ACT_W'($urandom_range(0, 3)), dsed_pkg::BYTE_W'($urandom));
        end
        3, 4: begin
          // Frame whose escape is followed by a random byte, which may close it or cut it short.
          send_item(dsed_pkg::ACT_BYTE, board.escape_code);
          send_item(dsed_pkg::ACT_BYTE, board.start_code);
          repeat ($urandom_range(0, 5)) send_item(dsed_pkg::ACT_BYTE, pick_plain());
          send_item(dsed_pkg::ACT_BYTE, board.escape_code);
          send_item(dsed_pkg::ACT_BYTE, pick_byte());
        end
        5: begin
          repeat ($urandom_range(60, 70)) send_item(dsed_pkg::ACT_BYTE, pick_plain());
          send_item(dsed_pkg::ACT_FLUSH, dsed_pkg::BYTE_W'($urandom));
        end
        6: begin
          send_item(dsed_pkg::ACT_BYTE, board.escape_code);
          send_item(dsed_pkg::ACT_BYTE, board.start_code);
          repeat (dsed_pkg::MAX_FRAME) send_item(dsed_pkg::ACT_BYTE, pick_plain());
          if ($urandom_range(0, 1) == 0) begin
            send_item(dsed_pkg::ACT_BYTE, pick_plain());
          end else begin
            send_item(dsed_pkg::ACT_BYTE, board.escape_code);
            send_item(dsed_pkg::ACT_BYTE, board.escape_code);
          end
          send_item(dsed_pkg::ACT_BYTE, board.escape_code);
          send_item(dsed_pkg::ACT_BYTE, board.end_code);
        end
        default: begin
          repeat ($urandom_range(0, 3)) send_item(dsed_pkg::ACT_BYTE, pick_plain());
          send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(11, dsed_pkg::MAX_FRAME)
                                                 : $urandom_range(0, 10));
        end
      endcase
    end
  endtask

  initial begin
    static raw_item_t corner_items[30] = '{
      '{dsed_pkg::ACT_BYTE, 8'h00}, '{dsed_pkg::ACT_BYTE, 8'hFF},
      '{dsed_pkg::ACT_FLUSH, 8'hA5},
      // Two escapes, then an ordinary byte, outside a frame.
      '{dsed_pkg::ACT_BYTE, dsed_pkg::ESCAPE_RESET},
      '{dsed_pkg::ACT_BYTE, dsed_pkg::ESCAPE_RESET}, '{dsed_pkg::ACT_BYTE, 8'h41},
      // Frame start releases the stray bytes; then a frame with a literal escape.
      '{dsed_pkg::ACT_BYTE, dsed_pkg::ESCAPE_RESET},
      '{dsed_pkg::ACT_BYTE, dsed_pkg::START_RESET}, '{dsed_pkg::ACT_BYTE, 8'h00},
      '{dsed_pkg::ACT_BYTE, dsed_pkg::ESCAPE_RESET},
      '{dsed_pkg::ACT_BYTE, dsed_pkg::ESCAPE_RESET}, '{dsed_pkg::ACT_BYTE, 8'hFF},
      '{dsed_pkg::ACT_BYTE, dsed_pkg::ESCAPE_RESET},
      '{dsed_pkg::ACT_BYTE, dsed_pkg::END_RESET},
      // Empty frame closed.
      '{dsed_pkg::ACT_BYTE, dsed_pkg::ESCAPE_RESET},
      '{dsed_pkg::ACT_BYTE, dsed_pkg::START_RESET},
      '{dsed_pkg::ACT_BYTE, dsed_pkg::ESCAPE_RESET},
      '{dsed_pkg::ACT_BYTE, dsed_pkg::END_RESET},
      // Restart inside a frame, then a bad escape drops it.
      '{dsed_pkg::ACT_BYTE, dsed_pkg::ESCAPE_RESET},
      '{dsed_pkg::ACT_BYTE, dsed_pkg::START_RESET}, '{dsed_pkg::ACT_BYTE, 8'h11},
      '{dsed_pkg::ACT_BYTE, dsed_pkg::ESCAPE_RESET},
      '{dsed_pkg::ACT_BYTE, dsed_pkg::START_RESET}, '{dsed_pkg::ACT_BYTE, 8'h22},
      '{dsed_pkg::ACT_BYTE, dsed_pkg::ESCAPE_RESET}, '{dsed_pkg::ACT_BYTE, 8'h55},
      '{dsed_pkg::ACT_BYTE_FLUSH, 8'h7E}, '{ACT_SPARE, 8'h00},
      '{dsed_pkg::ACT_BYTE, 8'h01}, '{ACT_SPARE, 8'hFF}
    };
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= dsed_pkg::REG_ESCAPE;
    cfg_data          <= '0;
    byte_in.valid     <= 1'b0;
    byte_in.action    <= dsed_pkg::ACT_BYTE;
    byte_in.data_byte <= '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (corner_items[i]) send_item(corner_items[i].act, corner_items[i].data);

    recv_stalls = 1'b1;
    // A full-size frame sent without gaps while the output is held off, so the
    // run is queued well inside the hold; the sender then keeps going with
    // stray bytes past the store's capacity.
    hold_request = 1'b1;
    send_frame(dsed_pkg::MAX_FRAME);
    send_gaps = 1'b1;
    repeat (dsed_pkg::MAX_FRAME + 6) send_item(dsed_pkg::ACT_BYTE, pick_plain());
    send_item(dsed_pkg::ACT_FLUSH, 8'h00);
    run_traffic(30);
    settle();

    write_codes(8'h00, 8'hFF, 8'h7F);
    run_traffic(40);
    settle();

    // Start and end share a value.
    write_codes(8'hFF, 8'h00, 8'h00);
    run_traffic(40);
    settle();

    // Escape and start share a value.
    write_reg(REG_SPARE, dsed_pkg::BYTE_W'($urandom));
    write_codes(8'h55, 8'h55, 8'hAA);
    run_traffic(40);
    settle();

    // Escape and end share a value.
    write_codes(8'h33, 8'h34, 8'h33);
    run_traffic(40);
    settle();

    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    write_codes(dsed_pkg::ESCAPE_RESET, dsed_pkg::START_RESET, dsed_pkg::END_RESET);
    run_traffic(30);
    settle();

    if (board.errors == 0 && board.pending_bytes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### dle_stx_etx_deframer_core.f
+incdir+rtl
rtl/dsed_pkg.sv
rtl/dsed_if.sv
rtl/dsed_front.sv
rtl/dsed_cmd_fifo.sv
rtl/dsed_back.sv
rtl/dle_stx_etx_deframer_core.sv
sim/dle_stx_etx_deframer_core_test.sv
